>>> rtl/core/acds_pkg.sv
// Shared types, codes and small arithmetic helpers for the alarm clock digit setter.
// No dependencies; every module of the block imports this package.
package acds_pkg;

    localparam int unsigned OpcodeW  = 3;
    localparam int unsigned HourW    = 5;
    localparam int unsigned MinuteW  = 6;
    localparam int unsigned AlMinW   = 7;
    localparam int unsigned DigitW   = 4;
    localparam int unsigned NumDigit = 4;
    localparam int unsigned SelW     = 2;
    localparam int unsigned ModeW    = 2;
    localparam int unsigned SnoozeW  = 6;
    localparam logic [SnoozeW-1:0] SnoozeReset = 6'd10;

    // Event kinds carried on the input tuser
    typedef enum logic [OpcodeW-1:0] {
        OP_TICK   = 3'd0,
        OP_SWITCH = 3'd1,
        OP_ENC    = 3'd2,
        OP_YES    = 3'd3,
        OP_NO     = 3'd4
    } t_op;

    // Controller mode, one-hot
    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_EDIT = 3'b010,
        MODE_RING = 3'b100
    } t_mode;

    // Mode codes as reported on the result
    localparam logic [ModeW-1:0] MODE_CODE_IDLE = 2'd0;
    localparam logic [ModeW-1:0] MODE_CODE_EDIT = 2'd1;
    localparam logic [ModeW-1:0] MODE_CODE_RING = 2'd2;

    typedef struct packed {
        logic [OpcodeW-1:0] opcode;
        logic               enc_dline;
        logic               enc_clk;
        logic [MinuteW-1:0] minute;
        logic [HourW-1:0]   hour;
    } t_in_item;

    typedef struct packed {
        logic              ring_stop;
        logic              ring_start;
        logic              armed_now;
        logic [SelW-1:0]   edit_position;
        logic [ModeW-1:0]  mode_now;
        logic [DigitW-1:0] disp_digit3;
        logic [DigitW-1:0] disp_digit2;
        logic [DigitW-1:0] disp_digit1;
        logic [DigitW-1:0] disp_digit0;
    } t_result;

    // v / 10 for v < 128 by reciprocal multiply (205 / 2048 is exact here)
    function automatic logic [DigitW-1:0] div10(input logic [AlMinW-1:0] v);
        logic [14:0] p;
        p = {8'd0, v} * 15'd205;
        return p[14:11];
    endfunction

    function automatic logic [DigitW-1:0] mod10(input logic [AlMinW-1:0] v);
        logic [AlMinW-1:0] q;
        logic [AlMinW-1:0] r;
        q = {3'd0, div10(v)};
        r = v - q * 7'd10;
        return r[DigitW-1:0];
    endfunction

endpackage

>>> rtl/core/acds_in_reg.sv
// Input register stage: holds one accepted event until the engine takes it.
// Depends on acds_pkg.
module acds_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  acds_pkg::t_in_item i_item,
    output logic               o_valid,
    input  logic               i_take,
    output acds_pkg::t_in_item o_item
);
    import acds_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // free slot, or the held event leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

>>> rtl/core/acds_engine.sv
// Controller state and next-state logic; one event per load, result registered.
// Depends on acds_pkg.
module acds_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  acds_pkg::t_in_item             i_item,
    input  logic [acds_pkg::SnoozeW-1:0]   i_snooze,
    output acds_pkg::t_result              o_result
);
    import acds_pkg::*;

    t_mode             r_mode,     n_mode;
    logic [DigitW-1:0] r_dig [NumDigit];
    logic [DigitW-1:0] n_dig [NumDigit];
    logic [SelW-1:0]   r_sel,      n_sel;
    logic              r_left,     n_left;
    logic              r_right,    n_right;
    logic [HourW-1:0]  r_al_hour,  n_al_hour;
    logic [AlMinW-1:0] r_al_min,   n_al_min;
    logic              r_armed,    n_armed;
    logic [HourW-1:0]  r_cur_hour, n_cur_hour;
    logic [MinuteW-1:0] r_cur_min, n_cur_min;
    t_result           r_res,      n_res;

    logic              start, stop;
    logic [DigitW-1:0] d_enc;
    logic [AlMinW-1:0] snz_sum;
    logic [AlMinW-1:0] snz_min;
    logic [1:0]        snz_carry;
    logic [5:0]        snz_hour;
    logic [7:0]        st_hour;
    logic [7:0]        st_min;
    logic [ModeW-1:0]  mode_code;

    // snooze time: current minute plus snooze, wrapped at 60, carry into the hour
    always_comb begin
        snz_sum = {1'b0, r_cur_min} + {1'b0, i_snooze};
        if (snz_sum >= 7'd120) begin
            snz_min   = snz_sum - 7'd120;
            snz_carry = 2'd2;
        end else if (snz_sum >= 7'd60) begin
            snz_min   = snz_sum - 7'd60;
            snz_carry = 2'd1;
        end else begin
            snz_min   = snz_sum;
            snz_carry = 2'd0;
        end
        snz_hour = {1'b0, r_cur_hour} + {4'd0, snz_carry};
        if (snz_hour >= 6'd24) begin
            snz_hour = snz_hour - 6'd24;
        end
    end

    // edited digits back to binary
    assign st_hour = {4'd0, r_dig[0]} * 8'd10 + {4'd0, r_dig[1]};
    assign st_min  = {4'd0, r_dig[2]} * 8'd10 + {4'd0, r_dig[3]};

    always_comb begin
        n_mode     = r_mode;
        n_dig      = r_dig;
        n_sel      = r_sel;
        n_left     = r_left;
        n_right    = r_right;
        n_al_hour  = r_al_hour;
        n_al_min   = r_al_min;
        n_armed    = r_armed;
        n_cur_hour = r_cur_hour;
        n_cur_min  = r_cur_min;
        start      = 1'b0;
        stop       = 1'b0;
        d_enc      = r_dig[r_sel];

        case (t_op'(i_item.opcode))
            OP_TICK: begin
                n_cur_hour = i_item.hour;
                n_cur_min  = i_item.minute;
                if (r_mode == MODE_IDLE && r_armed && r_al_hour == i_item.hour
                        && r_al_min == {1'b0, i_item.minute}) begin
                    n_mode = MODE_RING;
                    start  = 1'b1;
                end
            end
            OP_SWITCH: begin
                if (r_mode == MODE_IDLE) begin
                    n_mode   = MODE_EDIT;
                    n_sel    = '0;
                    n_dig[0] = div10({2'd0, r_al_hour});
                    n_dig[1] = mod10({2'd0, r_al_hour});
                    n_dig[2] = div10(r_al_min);
                    n_dig[3] = mod10(r_al_min);
                end else if (r_mode == MODE_EDIT) begin
                    n_sel = r_sel + 2'd1;
                end
            end
            OP_ENC: begin
                if (r_mode == MODE_EDIT) begin
                    if (!i_item.enc_clk) begin
                        // clock low arms a direction
                        if (!r_left && !i_item.enc_dline) begin
                            n_left  = 1'b1;
                            n_right = 1'b0;
                        end else if (i_item.enc_dline) begin
                            n_right = 1'b1;
                            n_left  = 1'b0;
                        end
                    end else begin
                        if (r_left && i_item.enc_dline) begin
                            d_enc  = (d_enc == 4'd0) ? 4'd9 : d_enc - 4'd1;
                            n_left = 1'b0;
                        end else if (r_right && !i_item.enc_dline) begin
                            d_enc   = (d_enc >= 4'd9) ? 4'd0 : d_enc + 4'd1;
                            n_right = 1'b0;
                        end
                    end
                    // hour tens limited to 0..2
                    if (r_sel == 2'd0 && d_enc > 4'd2) begin
                        d_enc = 4'd0;
                    end
                    n_dig[r_sel] = d_enc;
                end
            end
            OP_YES: begin
                if (r_mode == MODE_EDIT) begin
                    n_al_hour = st_hour[HourW-1:0];
                    n_al_min  = st_min[AlMinW-1:0];
                    n_armed   = 1'b1;
                    n_mode    = MODE_IDLE;
                    n_sel     = '0;
                end else if (r_mode == MODE_RING) begin
                    n_al_min  = snz_min;
                    n_al_hour = snz_hour[HourW-1:0];
                    n_mode    = MODE_IDLE;
                    stop      = 1'b1;
                end
            end
            OP_NO: begin
                if (r_mode == MODE_EDIT) begin
                    n_mode = MODE_IDLE;
                    n_sel  = '0;
                end else begin
                    n_al_hour = '0;
                    n_al_min  = '0;
                    n_armed   = 1'b0;
                    if (r_mode == MODE_RING) begin
                        n_mode = MODE_IDLE;
                        stop   = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        case (n_mode)
            MODE_EDIT: mode_code = MODE_CODE_EDIT;
            MODE_RING: mode_code = MODE_CODE_RING;
            default:   mode_code = MODE_CODE_IDLE;
        endcase
    end

    always_comb begin
        if (n_mode == MODE_EDIT) begin
            n_res.disp_digit0 = n_dig[0];
            n_res.disp_digit1 = n_dig[1];
            n_res.disp_digit2 = n_dig[2];
            n_res.disp_digit3 = n_dig[3];
        end else begin
            n_res.disp_digit0 = div10({2'd0, n_cur_hour});
            n_res.disp_digit1 = mod10({2'd0, n_cur_hour});
            n_res.disp_digit2 = div10({1'b0, n_cur_min});
            n_res.disp_digit3 = mod10({1'b0, n_cur_min});
        end
        n_res.mode_now      = mode_code;
        n_res.edit_position = n_sel;
        n_res.armed_now     = n_armed;
        n_res.ring_start    = start;
        n_res.ring_stop     = stop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_dig      <= '{default: '0};
            r_sel      <= '0;
            r_left     <= 1'b0;
            r_right    <= 1'b0;
            r_al_hour  <= '0;
            r_al_min   <= '0;
            r_armed    <= 1'b0;
            r_cur_hour <= '0;
            r_cur_min  <= '0;
        end else if (i_load) begin
            r_mode     <= n_mode;
            r_dig      <= n_dig;
            r_sel      <= n_sel;
            r_left     <= n_left;
            r_right    <= n_right;
            r_al_hour  <= n_al_hour;
            r_al_min   <= n_al_min;
            r_armed    <= n_armed;
            r_cur_hour <= n_cur_hour;
            r_cur_min  <= n_cur_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= n_res;
        end
    end

    assign o_result = r_res;

endmodule

>>> rtl/core/alarm_clock_digit_setter.sv
// Top level of the alarm clock digit setter: stream ports, snooze register,
// input register and engine. Depends on acds_pkg, acds_in_reg, acds_engine.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  tuser opcode, tdata time + encoder
//   m_axis    out  m_axis_tvalid / m_axis_tready  tdata digits, mode, flags
//   cfg       in   i_cfg_valid / o_cfg_ready      snooze minutes
//
// One event per cycle sustained while m_axis does not stall; each event passes
// the input register, then the result register fed by the engine logic.
// Synchronous active-low reset: idle, alarm cleared, snooze back to 10.
// A stall on m_axis holds the result; the input register still takes one
// more event, then s_axis_tready drops until the result is taken.
module alarm_clock_digit_setter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [15:0]                  s_axis_tdata,  // hour, minute, enc_clk, enc_dline
    input  logic [acds_pkg::OpcodeW-1:0] s_axis_tuser,  // opcode
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // digit0..3, mode_now, edit_position, armed_now, ring_start, ring_stop
    output logic [23:0]                  m_axis_tdata,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [acds_pkg::SnoozeW-1:0] i_cfg_data
);
    import acds_pkg::*;

    t_in_item           s_item;
    t_in_item           held_item;
    logic               held_valid;
    logic               take;
    logic               out_adv;
    logic               r_out_valid;
    logic [SnoozeW-1:0] r_snooze;
    t_result            result;

    assign s_item.opcode    = s_axis_tuser;
    assign s_item.hour      = s_axis_tdata[4:0];
    assign s_item.minute    = s_axis_tdata[10:5];
    assign s_item.enc_clk   = s_axis_tdata[11];
    assign s_item.enc_dline = s_axis_tdata[12];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snooze <= SnoozeReset;
        end else if (i_cfg_valid) begin
            r_snooze <= i_cfg_data;
        end
    end

    // result slot free or being drained this cycle
    assign out_adv = !r_out_valid || m_axis_tready;
    assign take    = held_valid && out_adv;

    acds_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (s_item),
        .o_valid (held_valid),
        .i_take  (take),
        .o_item  (held_item)
    );

    acds_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take),
        .i_item   (held_item),
        .i_snooze (r_snooze),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= held_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, result};

endmodule
